@@ src/predictive_lap_timer_top_macros.svh @@
// assertion helpers for the lap timer top level
`ifndef PREDICTIVE_LAP_TIMER_TOP_MACROS_SVH
`define PREDICTIVE_LAP_TIMER_TOP_MACROS_SVH

// condition must never hold outside reset
`define PLT_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("plt: forbidden condition");

// antecedent in one cycle implies consequent in the next
`define PLT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("plt: sequence broken");

`endif

@@ src/plt_pkg.sv @@
package plt_pkg;

    localparam int SAMPLE_DEPTH = 128;
    localparam int IDX_W        = $clog2(SAMPLE_DEPTH);
    localparam int ADDR_W       = IDX_W + 1;
    localparam int HALF_DEPTH   = SAMPLE_DEPTH / 2;
    localparam int K_W          = IDX_W - 1;

    localparam int DVD_W     = 64;
    localparam int DVS_W     = 32;
    localparam int DIV_CNT_W = $clog2(DVD_W);

    localparam logic [1:0] KIND_SAMPLE  = 2'd0;
    localparam logic [1:0] KIND_END     = 2'd1;
    localparam logic [1:0] KIND_PREDICT = 2'd2;

    localparam logic [7:0]  STEP_LIMIT = 8'd255;
    localparam logic [7:0]  ITEM_LIMIT = 8'd255;
    localparam logic [23:0] SUM_LIMIT  = 24'hFF_FFFF;
    localparam logic [31:0] TIME_CAP   = 32'hFFFF_FFFF;
    localparam logic [31:0] SPEED_CAP  = 32'h0000_FFFF;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] speed;
        logic [15:0] distance_step;
        logic [15:0] time_step;
    } item_t;

    typedef struct packed {
        logic [31:0] predicted_time;
        logic        match_found;
        logic        degenerate;
    } result_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_END, ST_S_CHK, ST_SQ_RD, ST_SQ_WR, ST_SQ_END, ST_S_RD,
        ST_S_DIV, ST_S_WAIT, ST_S_WR, ST_P_RD0, ST_P_RD1, ST_P_START,
        ST_P_SRD, ST_P_SCMP, ST_P_MISS, ST_P_EVAL, ST_P_DEGEN, ST_P_TMUL,
        ST_P_TDIV, ST_P_TWAIT, ST_P_TFIN, ST_P_SMUL, ST_P_SDIV, ST_P_SWAIT,
        ST_P_SFIN, ST_P_DIFF, ST_P_RMUL, ST_P_RDIV, ST_P_RWAIT, ST_P_OUT
    } ctrl_state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LATCH, OP_END, OP_SQ_INIT, OP_SQ_RD, OP_SQ_WR, OP_SQ_END,
        OP_S_RD, OP_S_WR, OP_DIV, OP_P_RD0, OP_P_RD1, OP_P_START, OP_P_SRD,
        OP_P_SCMP, OP_P_MISS, OP_P_EVAL, OP_P_DEGEN, OP_P_TMUL, OP_P_TFIN,
        OP_P_SMUL, OP_P_SFIN, OP_P_DIFF, OP_P_RMUL, OP_P_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } cmd_t;

    typedef struct packed {
        logic new_bucket;
        logic bank_full;
        logic sq_last;
        logic found;
        logic at_last;
        logic skip;
        logic div_done;
    } status_t;

endpackage

@@ src/plt_div.sv @@
module plt_div
    import plt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic [DVD_W-1:0] quotient,
    output logic             done
);

    logic [DVD_W-1:0]     quo_reg, quo_next;
    logic [DVS_W-1:0]     rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 run_reg;
    logic                 done_reg;
    logic [DVS_W:0]       trial;

    // one quotient bit a cycle, restoring
    always_comb
    begin
        trial = {rem_reg, quo_reg[DVD_W-1]};
        if (trial >= {1'b0, divisor})
        begin
            rem_next = DVS_W'(trial - {1'b0, divisor});
            quo_next = {quo_reg[DVD_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[DVS_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DVD_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

@@ src/plt_dp.sv @@
module plt_dp
    import plt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  item_t   item,
    input  cmd_t    cmd,
    output status_t status,
    output result_t result,
    output logic    result_valid
);

    // bucket memories, both banks, bank in the top address bit
    logic [31:0] mem_dist  [2*SAMPLE_DEPTH];
    logic [31:0] mem_time  [2*SAMPLE_DEPTH];
    logic [15:0] mem_speed [2*SAMPLE_DEPTH];

    item_t            in_reg;
    logic             bank_reg;
    logic [IDX_W-1:0] fill_reg [2];
    logic [7:0]       dstep_reg [2];
    logic [7:0]       items_reg;
    logic [23:0]      sum_reg;
    logic [IDX_W-1:0] cached_reg;
    logic [1:0]       e0_reg;
    logic [K_W-1:0]   k_reg;
    logic [IDX_W-1:0] i_reg;
    logic             result_valid_reg;
    result_t          result_reg;

    logic [31:0] rda_dist_reg, rda_time_reg, rdb_dist_reg, rdb_time_reg;
    logic [15:0] rda_speed_reg, rdb_speed_reg;
    logic        rda_z_reg, rdb_z_reg;
    logic [31:0] rda_dist, rda_time, rdb_dist, rdb_time;
    logic [15:0] rda_speed, rdb_speed;

    logic [31:0] d_reg, elapsed_reg, total_reg;
    logic [31:0] mdx_reg, span_reg, mdyt_reg, time_at_reg, diff_reg;
    logic [15:0] mdys_reg, speed_at_reg;
    logic        negx_reg, negspan_reg, negyt_reg, negys_reg;
    logic [DVD_W-1:0] prod_reg;
    logic [DVS_W-1:0] dsor_reg;

    logic              rd_a_en, rd_b_en, wr_en;
    logic [ADDR_W-1:0] rd_a_addr, rd_b_addr, wr_addr;
    logic [31:0]       wr_dist, wr_time;
    logic [15:0]       wr_speed;

    logic             cb, pb;
    logic [IDX_W-1:0] cur_fill, last;
    logic [31:0]      d2;
    logic [7:0]       items_next;
    logic [23:0]      sum_next;
    logic [24:0]      sum_wide;
    logic [32:0]      dist_sum, time_sum;
    logic [16:0]      speed_pair;
    logic [63:0]      out_sum;
    logic [31:0]      blend_t, blend_s;

    logic             div_start, div_done;
    logic [DVD_W-1:0] quotient;

    function automatic logic [31:0] blend_fin(input logic [63:0] q, input logic [31:0] base,
                                              input logic neg, input logic [31:0] cap);
        logic [64:0] s;
        logic [31:0] r;
        s = {1'b0, q} + {33'b0, base};
        if (neg)
            r = (q >= {32'b0, base}) ? 32'd0 : base - q[31:0];
        else
            r = (s > {33'b0, cap}) ? cap : s[31:0];
        return r;
    endfunction

    assign cb       = bank_reg;
    assign pb       = ~bank_reg;
    assign cur_fill = fill_reg[cb];
    assign last     = fill_reg[pb];

    // entry 0 reads as zero until written after reset or lap swap
    assign rda_dist  = rda_z_reg ? 32'd0 : rda_dist_reg;
    assign rda_time  = rda_z_reg ? 32'd0 : rda_time_reg;
    assign rda_speed = rda_z_reg ? 16'd0 : rda_speed_reg;
    assign rdb_dist  = rdb_z_reg ? 32'd0 : rdb_dist_reg;
    assign rdb_time  = rdb_z_reg ? 32'd0 : rdb_time_reg;
    assign rdb_speed = rdb_z_reg ? 16'd0 : rdb_speed_reg;

    assign status.new_bucket = items_reg >= dstep_reg[cb];
    assign status.bank_full  = cur_fill == IDX_W'(SAMPLE_DEPTH - 1);
    assign status.sq_last    = k_reg == K_W'(HALF_DEPTH - 1);
    assign status.at_last    = i_reg == last;
    assign d2                = status.at_last ? rda_dist : rdb_dist;
    assign status.found      = (d_reg < rda_dist) || (d_reg < d2);
    assign status.skip       = (in_reg.speed == 16'd0)
                               || (!status.at_last && (rda_dist == rdb_dist));
    assign status.div_done   = div_done;

    assign sum_wide   = {1'b0, sum_reg} + {9'b0, in_reg.speed};
    assign items_next = status.new_bucket ? 8'd1
                        : ((items_reg < ITEM_LIMIT) ? items_reg + 8'd1 : items_reg);
    assign sum_next   = status.new_bucket ? {8'b0, in_reg.speed}
                        : (sum_wide > {1'b0, SUM_LIMIT} ? SUM_LIMIT : sum_wide[23:0]);
    assign dist_sum   = {1'b0, rda_dist} + {17'b0, in_reg.distance_step};
    assign time_sum   = {1'b0, rda_time} + {17'b0, in_reg.time_step};
    assign speed_pair = {1'b0, rda_speed} + {1'b0, rdb_speed};
    assign out_sum    = {32'b0, elapsed_reg} + quotient;
    assign blend_t    = blend_fin(quotient, rda_time, negx_reg ^ negyt_reg ^ negspan_reg,
                                  TIME_CAP);
    assign blend_s    = blend_fin(quotient, {16'b0, rda_speed},
                                  negx_reg ^ negys_reg ^ negspan_reg, SPEED_CAP);
    assign div_start  = cmd.op == OP_DIV;

    // memory addressing per step
    always_comb
    begin
        rd_a_en   = 1'b0;
        rd_b_en   = 1'b0;
        rd_a_addr = '0;
        rd_b_addr = '0;
        wr_en     = 1'b0;
        wr_addr   = '0;
        wr_dist   = rdb_dist;
        wr_time   = rdb_time;
        wr_speed  = speed_pair[16:1];
        unique case (cmd.op)
            OP_SQ_RD:
            begin
                rd_a_en   = 1'b1;
                rd_b_en   = 1'b1;
                rd_a_addr = {cb, k_reg, 1'b0};
                rd_b_addr = {cb, k_reg, 1'b1};
            end
            OP_SQ_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = {cb, 1'b0, k_reg};
            end
            OP_S_RD:
            begin
                rd_a_en   = 1'b1;
                rd_a_addr = {cb, cur_fill};
            end
            OP_S_WR:
            begin
                wr_en    = 1'b1;
                wr_addr  = {cb, cur_fill};
                wr_dist  = dist_sum[32] ? TIME_CAP : dist_sum[31:0];
                wr_time  = time_sum[32] ? TIME_CAP : time_sum[31:0];
                wr_speed = quotient[15:0];
            end
            OP_P_RD0:
            begin
                rd_a_en   = 1'b1;
                rd_b_en   = 1'b1;
                rd_a_addr = {cb, cur_fill};
                rd_b_addr = {pb, last};
            end
            OP_P_RD1:
            begin
                rd_a_en   = 1'b1;
                rd_a_addr = {pb, cached_reg};
            end
            OP_P_SRD:
            begin
                rd_a_en   = 1'b1;
                rd_b_en   = 1'b1;
                rd_a_addr = {pb, i_reg};
                rd_b_addr = {pb, IDX_W'(i_reg + 1'b1)};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_dist[wr_addr]  <= wr_dist;
            mem_time[wr_addr]  <= wr_time;
            mem_speed[wr_addr] <= wr_speed;
        end
        if (rd_a_en)
        begin
            rda_dist_reg  <= mem_dist[rd_a_addr];
            rda_time_reg  <= mem_time[rd_a_addr];
            rda_speed_reg <= mem_speed[rd_a_addr];
            rda_z_reg     <= (rd_a_addr[IDX_W-1:0] == '0) && e0_reg[rd_a_addr[ADDR_W-1]];
        end
        if (rd_b_en)
        begin
            rdb_dist_reg  <= mem_dist[rd_b_addr];
            rdb_time_reg  <= mem_time[rd_b_addr];
            rdb_speed_reg <= mem_speed[rd_b_addr];
            rdb_z_reg     <= (rd_b_addr[IDX_W-1:0] == '0) && e0_reg[rd_b_addr[ADDR_W-1]];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg         <= 1'b0;
            fill_reg[0]      <= '0;
            fill_reg[1]      <= '0;
            dstep_reg[0]     <= 8'd1;
            dstep_reg[1]     <= 8'd1;
            items_reg        <= '0;
            sum_reg          <= '0;
            cached_reg       <= '0;
            e0_reg           <= 2'b11;
            k_reg            <= '0;
            i_reg            <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= (cmd.op == OP_P_MISS) || (cmd.op == OP_P_DEGEN)
                                || (cmd.op == OP_P_OUT);
            if (wr_en && (wr_addr[IDX_W-1:0] == '0))
                e0_reg[wr_addr[ADDR_W-1]] <= 1'b0;
            unique case (cmd.op)
                OP_END:
                begin
                    bank_reg      <= pb;
                    fill_reg[pb]  <= '0;
                    dstep_reg[pb] <= 8'd1;
                    e0_reg[pb]    <= 1'b1;
                    items_reg     <= '0;
                    sum_reg       <= '0;
                    cached_reg    <= '0;
                end
                OP_SQ_INIT: k_reg <= '0;
                OP_SQ_WR:   k_reg <= k_reg + 1'b1;
                OP_SQ_END:
                begin
                    fill_reg[cb] <= IDX_W'(HALF_DEPTH - 1);
                    // the sample after a squeeze always opens a fresh bucket
                    items_reg    <= ITEM_LIMIT;
                    if (dstep_reg[cb] < STEP_LIMIT)
                        dstep_reg[cb] <= dstep_reg[cb] + 8'd1;
                end
                OP_S_RD:
                begin
                    if (status.new_bucket)
                        fill_reg[cb] <= cur_fill + 1'b1;
                    items_reg <= items_next;
                    sum_reg   <= sum_next;
                end
                OP_P_START:
                    i_reg <= ((cached_reg > last) || (d_reg < rda_dist)) ? '0 : cached_reg;
                OP_P_SCMP:
                    if (!status.found && !status.at_last)
                        i_reg <= i_reg + 1'b1;
                OP_P_MISS: cached_reg <= '0;
                OP_P_EVAL: cached_reg <= i_reg;
                default:
                begin
                end
            endcase
        end
    end

    // datapath words
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LATCH: in_reg <= item;
            OP_S_RD:
            begin
                prod_reg <= DVD_W'(sum_next);
                dsor_reg <= DVS_W'(items_next);
            end
            OP_P_RD1:
            begin
                d_reg       <= rda_dist;
                elapsed_reg <= rda_time;
                total_reg   <= rdb_time;
            end
            OP_P_EVAL:
            begin
                negx_reg     <= d_reg < rda_dist;
                mdx_reg      <= (d_reg < rda_dist) ? rda_dist - d_reg : d_reg - rda_dist;
                negspan_reg  <= rdb_dist < rda_dist;
                span_reg     <= (rdb_dist < rda_dist) ? rda_dist - rdb_dist
                                                      : rdb_dist - rda_dist;
                negyt_reg    <= rdb_time < rda_time;
                mdyt_reg     <= (rdb_time < rda_time) ? rda_time - rdb_time
                                                      : rdb_time - rda_time;
                negys_reg    <= rdb_speed < rda_speed;
                mdys_reg     <= (rdb_speed < rda_speed) ? rda_speed - rdb_speed
                                                        : rdb_speed - rda_speed;
                time_at_reg  <= rda_time;
                speed_at_reg <= rda_speed;
            end
            OP_P_TMUL:
            begin
                prod_reg <= mdx_reg * mdyt_reg;
                dsor_reg <= span_reg;
            end
            OP_P_TFIN: time_at_reg <= blend_t;
            OP_P_SMUL: prod_reg <= DVD_W'(mdx_reg * mdys_reg);
            OP_P_SFIN: speed_at_reg <= blend_s[15:0];
            OP_P_DIFF:
                diff_reg <= (total_reg > time_at_reg) ? total_reg - time_at_reg : 32'd0;
            OP_P_RMUL:
            begin
                prod_reg <= DVD_W'(diff_reg * speed_at_reg);
                dsor_reg <= DVS_W'(in_reg.speed);
            end
            OP_P_MISS:  result_reg <= '{predicted_time: elapsed_reg, match_found: 1'b0,
                                        degenerate: 1'b0};
            OP_P_DEGEN: result_reg <= '{predicted_time: elapsed_reg, match_found: 1'b1,
                                        degenerate: 1'b1};
            OP_P_OUT:
                result_reg <= '{predicted_time: (out_sum > {32'b0, TIME_CAP}) ? TIME_CAP
                                                                              : out_sum[31:0],
                                match_found: 1'b1, degenerate: 1'b0};
            default:
            begin
            end
        endcase
    end

    plt_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (dsor_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

@@ src/plt_ctrl.sv @@
module plt_ctrl
    import plt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] kind,
    input  status_t    status,
    output cmd_t       cmd,
    output logic       busy
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            ST_IDLE:
                if (start)
                begin
                    cmd.op = OP_LATCH;
                    if (kind == KIND_SAMPLE)
                        state_next = ST_S_CHK;
                    else if (kind == KIND_END)
                        state_next = ST_END;
                    else if (kind == KIND_PREDICT)
                        state_next = ST_P_RD0;
                end
            ST_END:
            begin
                cmd.op     = OP_END;
                state_next = ST_IDLE;
            end
            ST_S_CHK:
            begin
                cmd.op     = OP_SQ_INIT;
                state_next = (status.new_bucket && status.bank_full) ? ST_SQ_RD : ST_S_RD;
            end
            ST_SQ_RD:
            begin
                cmd.op     = OP_SQ_RD;
                state_next = ST_SQ_WR;
            end
            ST_SQ_WR:
            begin
                cmd.op     = OP_SQ_WR;
                state_next = status.sq_last ? ST_SQ_END : ST_SQ_RD;
            end
            ST_SQ_END:
            begin
                cmd.op     = OP_SQ_END;
                state_next = ST_S_RD;
            end
            ST_S_RD:
            begin
                cmd.op     = OP_S_RD;
                state_next = ST_S_DIV;
            end
            ST_S_DIV:
            begin
                cmd.op     = OP_DIV;
                state_next = ST_S_WAIT;
            end
            ST_S_WAIT:
                if (status.div_done)
                    state_next = ST_S_WR;
            ST_S_WR:
            begin
                cmd.op     = OP_S_WR;
                state_next = ST_IDLE;
            end
            ST_P_RD0:
            begin
                cmd.op     = OP_P_RD0;
                state_next = ST_P_RD1;
            end
            ST_P_RD1:
            begin
                cmd.op     = OP_P_RD1;
                state_next = ST_P_START;
            end
            ST_P_START:
            begin
                cmd.op     = OP_P_START;
                state_next = ST_P_SRD;
            end
            ST_P_SRD:
            begin
                cmd.op     = OP_P_SRD;
                state_next = ST_P_SCMP;
            end
            ST_P_SCMP:
            begin
                cmd.op = OP_P_SCMP;
                priority if (status.found)
                    state_next = ST_P_EVAL;
                else if (status.at_last)
                    state_next = ST_P_MISS;
                else
                    state_next = ST_P_SRD;
            end
            ST_P_MISS:
            begin
                cmd.op     = OP_P_MISS;
                state_next = ST_IDLE;
            end
            ST_P_EVAL:
            begin
                cmd.op = OP_P_EVAL;
                priority if (status.skip)
                    state_next = ST_P_DEGEN;
                else if (status.at_last)
                    state_next = ST_P_DIFF;
                else
                    state_next = ST_P_TMUL;
            end
            ST_P_DEGEN:
            begin
                cmd.op     = OP_P_DEGEN;
                state_next = ST_IDLE;
            end
            ST_P_TMUL:
            begin
                cmd.op     = OP_P_TMUL;
                state_next = ST_P_TDIV;
            end
            ST_P_TDIV:
            begin
                cmd.op     = OP_DIV;
                state_next = ST_P_TWAIT;
            end
            ST_P_TWAIT:
                if (status.div_done)
                    state_next = ST_P_TFIN;
            ST_P_TFIN:
            begin
                cmd.op     = OP_P_TFIN;
                state_next = ST_P_SMUL;
            end
            ST_P_SMUL:
            begin
                cmd.op     = OP_P_SMUL;
                state_next = ST_P_SDIV;
            end
            ST_P_SDIV:
            begin
                cmd.op     = OP_DIV;
                state_next = ST_P_SWAIT;
            end
            ST_P_SWAIT:
                if (status.div_done)
                    state_next = ST_P_SFIN;
            ST_P_SFIN:
            begin
                cmd.op     = OP_P_SFIN;
                state_next = ST_P_DIFF;
            end
            ST_P_DIFF:
            begin
                cmd.op     = OP_P_DIFF;
                state_next = ST_P_RMUL;
            end
            ST_P_RMUL:
            begin
                cmd.op     = OP_P_RMUL;
                state_next = ST_P_RDIV;
            end
            ST_P_RDIV:
            begin
                cmd.op     = OP_DIV;
                state_next = ST_P_RWAIT;
            end
            ST_P_RWAIT:
                if (status.div_done)
                    state_next = ST_P_OUT;
            ST_P_OUT:
            begin
                cmd.op     = OP_P_OUT;
                state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign busy = state_reg != ST_IDLE;

endmodule

@@ src/predictive_lap_timer_top.sv @@
// channel   | signals                         | handshake
// ----------+---------------------------------+----------------------------------
// item in   | start, busy, item (item_t)      | word taken when start && !busy
// result    | result_valid, result (result_t) | one-cycle strobe, cannot be held
//
// a sample word is dominated by the shared divider forming the bucket speed
// average; a sample that needs a new bucket while the bank is full first
// compacts the bank, merging bucket pairs
// a predict word scans the buckets of the last lap, then runs up to three
// divisions (time, speed, remaining time)
// reset leaves both banks empty; entry 0 of each bank reads as zero until
// written, so no clearing pass is needed
// busy stays high until the word is finished; the result register lets the
// next word be taken in the same cycle its result is strobed
`include "predictive_lap_timer_top_macros.svh"

module predictive_lap_timer_top
    import plt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  item_t   item,
    output logic    busy,
    output result_t result,
    output logic    result_valid
);

    // command and status between sequencer and datapath
    cmd_t    cmd;
    status_t status;

    // sequencer: one state per datapath step
    plt_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .kind   (item.kind),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // bucket memories, scan pointer, interpolation and shared divider
    plt_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .result       (result),
        .result_valid (result_valid)
    );

    // a degenerate result always comes with a match
    `PLT_ASSERT_NEVER(a_degen_needs_match,
        result_valid && result.degenerate && !result.match_found)

    // a result strobe is never held over
    `PLT_ASSERT_NEXT(a_strobe_single, result_valid, !result_valid)

    // any real word keeps the block busy in the next cycle
    `PLT_ASSERT_NEXT(a_busy_after_take,
        start && !busy && (item.kind == KIND_SAMPLE || item.kind == KIND_END
                           || item.kind == KIND_PREDICT),
        busy)

endmodule
